// ----- rtl/srsm_pkg.sv -----
// Shared types, codes and microcode ROM for the section rank-to-slot map.
package srsm_pkg;

	localparam int MaxSectionsDef = 16;
	localparam int FUNC_W         = 2;
	localparam int CNT_W          = 16;
	localparam int RANK_W         = 36;
	localparam int SLOT_W         = 20;
	localparam int SLOT_TOT_W     = 21;
	localparam int STAT_W         = 2;

	localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FN_RANK   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SIZE   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CNT_W-1:0]  sec_count;
		logic [CNT_W-1:0]  sec_size;
		logic [RANK_W-1:0] rank_index;
		logic [SLOT_W-1:0] slot_index;
	} cmd_word_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] answer;
		logic [RANK_W-1:0] total_ranks;
		logic [SLOT_W-1:0] total_slots;
	} rsp_word_t;

	// datapath operations
	localparam logic [3:0] OP_NOP      = 4'd0;
	localparam logic [3:0] OP_CLEAR    = 4'd1;
	localparam logic [3:0] OP_APP_MUL  = 4'd2;
	localparam logic [3:0] OP_APP_ADD  = 4'd3;
	localparam logic [3:0] OP_SET_FULL = 4'd4;
	localparam logic [3:0] OP_SET_OOR  = 4'd5;
	localparam logic [3:0] OP_SPAN     = 4'd6;
	localparam logic [3:0] OP_RSTEP    = 4'd7;
	localparam logic [3:0] OP_DIV      = 4'd8;
	localparam logic [3:0] OP_RANS     = 4'd9;
	localparam logic [3:0] OP_SSTEP    = 4'd10;
	localparam logic [3:0] OP_POST     = 4'd11;

	// jump conditions
	localparam logic [3:0] C_NEVER    = 4'd0;
	localparam logic [3:0] C_ALWAYS   = 4'd1;
	localparam logic [3:0] C_ACC      = 4'd2;
	localparam logic [3:0] C_IS_RANK  = 4'd3;
	localparam logic [3:0] C_IS_SIZE  = 4'd4;
	localparam logic [3:0] C_NOT_APP  = 4'd5;
	localparam logic [3:0] C_FULL     = 4'd6;
	localparam logic [3:0] C_RANK_OOR = 4'd7;
	localparam logic [3:0] C_SLOT_OOR = 4'd8;
	localparam logic [3:0] C_WALK_END = 4'd9;
	localparam logic [3:0] C_RMISS    = 4'd10;
	localparam logic [3:0] C_SMISS    = 4'd11;
	localparam logic [3:0] C_DIV_LAST = 4'd12;
	localparam logic [3:0] C_OUT_FREE = 4'd13;

	localparam int PC_W = 5;

	// program labels
	localparam logic [PC_W-1:0] L_IDLE  = 5'd0;
	localparam logic [PC_W-1:0] L_DISP  = 5'd1;
	localparam logic [PC_W-1:0] L_DISP2 = 5'd2;
	localparam logic [PC_W-1:0] L_DISP3 = 5'd3;
	localparam logic [PC_W-1:0] L_A0    = 5'd4;
	localparam logic [PC_W-1:0] L_A1    = 5'd5;
	localparam logic [PC_W-1:0] L_A2    = 5'd6;
	localparam logic [PC_W-1:0] L_AFULL = 5'd7;
	localparam logic [PC_W-1:0] L_R0    = 5'd8;
	localparam logic [PC_W-1:0] L_RWALK = 5'd9;
	localparam logic [PC_W-1:0] L_RSPAN = 5'd10;
	localparam logic [PC_W-1:0] L_RSTEP = 5'd11;
	localparam logic [PC_W-1:0] L_DIV   = 5'd12;
	localparam logic [PC_W-1:0] L_RANS  = 5'd13;
	localparam logic [PC_W-1:0] L_S0    = 5'd14;
	localparam logic [PC_W-1:0] L_SWALK = 5'd15;
	localparam logic [PC_W-1:0] L_SSTEP = 5'd16;
	localparam logic [PC_W-1:0] L_FIN   = 5'd17;
	localparam logic [PC_W-1:0] L_OOR   = 5'd18;

	// hold: stay on this step while the condition is false
	typedef struct packed {
		logic [3:0]      op;
		logic [3:0]      cond;
		logic            hold;
		logic [PC_W-1:0] tgt;
	} uword_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			L_IDLE:  w = '{OP_CLEAR,    C_ACC,      1'b1, L_DISP};
			L_DISP:  w = '{OP_NOP,      C_IS_RANK,  1'b0, L_R0};
			L_DISP2: w = '{OP_NOP,      C_IS_SIZE,  1'b0, L_S0};
			L_DISP3: w = '{OP_NOP,      C_NOT_APP,  1'b0, L_FIN};
			L_A0:    w = '{OP_NOP,      C_FULL,     1'b0, L_AFULL};
			L_A1:    w = '{OP_APP_MUL,  C_NEVER,    1'b0, L_IDLE};
			L_A2:    w = '{OP_APP_ADD,  C_ALWAYS,   1'b0, L_FIN};
			L_AFULL: w = '{OP_SET_FULL, C_ALWAYS,   1'b0, L_FIN};
			L_R0:    w = '{OP_NOP,      C_RANK_OOR, 1'b0, L_OOR};
			L_RWALK: w = '{OP_NOP,      C_WALK_END, 1'b0, L_OOR};
			L_RSPAN: w = '{OP_SPAN,     C_NEVER,    1'b0, L_IDLE};
			L_RSTEP: w = '{OP_RSTEP,    C_RMISS,    1'b0, L_RWALK};
			L_DIV:   w = '{OP_DIV,      C_DIV_LAST, 1'b1, L_RANS};
			L_RANS:  w = '{OP_RANS,     C_ALWAYS,   1'b0, L_FIN};
			L_S0:    w = '{OP_NOP,      C_SLOT_OOR, 1'b0, L_OOR};
			L_SWALK: w = '{OP_NOP,      C_WALK_END, 1'b0, L_OOR};
			L_SSTEP: w = '{OP_SSTEP,    C_SMISS,    1'b0, L_SWALK};
			L_FIN:   w = '{OP_POST,     C_OUT_FREE, 1'b1, L_IDLE};
			L_OOR:   w = '{OP_SET_OOR,  C_ALWAYS,   1'b0, L_FIN};
			default: w = '{OP_NOP,      C_ALWAYS,   1'b0, L_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/srsm_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
interface srsm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/srsm_div.sv -----
// Restoring divider, one quotient bit per step, for 32/16 with a 16-bit quotient.
module srsm_div
	import srsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [2*CNT_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [CNT_W-1:0] quotient,
	output logic             last
);

	localparam int STEP_W = $clog2(CNT_W);

	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	// remainder stays below divisor, so the trial fits one extra bit
	assign trial = {rem_q, quo_q[CNT_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctl.load) begin
			step_q <= '0;
		end else if (ctl.step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= dividend[2*CNT_W-1:CNT_W];
			quo_q <= dividend[CNT_W-1:0];
		end else if (ctl.step) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[CNT_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign last     = (step_q == '1);

endmodule

// ----- rtl/section_rank_to_slot_map_core.sv -----
// Section rank-to-slot map: microcoded sequencer over a section table.
//
// Usage: one command word in on cmd, one response word out on rsp, both
// valid/ready, a word moving when valid and ready are high at a clock edge.
// func selects append (store count/size, bump totals), rank-to-slot, or
// slot-to-size; every response carries status, answer and the totals.
// cmd.ready is high only while the sequencer sits at its idle step, so one
// command is worked on at a time. A finished response goes into an output
// register; the next command can be taken in the following cycle, while that response waits.
// Lookup time is set by the walk over the table memory (one read port, one
// section per pass of its walk steps: check, span, step for rank-to-slot;
// check, step for slot-to-size) and the 16-step serial divider.
// Reset clears the step counter, the section count and the totals; the table
// memory holds no reset and only stored entries are ever used.
// If the output register is full and rsp.ready is low, the sequencer holds at
// its final step until that register frees up; nothing is dropped.
module section_rank_to_slot_map_core
	import srsm_pkg::*;
#(
	parameter int MAX_SECTIONS = MaxSectionsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	srsm_chan_if.sink   cmd,
	srsm_chan_if.source rsp
);

	localparam int USED_W = $clog2(MAX_SECTIONS + 1);
	localparam int IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int OFS_W  = RANK_W + USED_W;      // running rank offset
	localparam int POS_W  = SLOT_TOT_W + USED_W;  // running slot position
	localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_SECTIONS);

	// sequencer
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	uword_t          uw;
	logic            cond_true;

	// command latch
	logic [FUNC_W-1:0] func_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  size_q;
	logic [RANK_W-1:0] rank_q;
	logic [SLOT_W-1:0] slot_q;

	// persistent state
	logic [USED_W-1:0]     used_q;
	logic [RANK_W-1:0]     rank_total_q;
	logic [SLOT_TOT_W-1:0] slot_total_q;

	// walk datapath
	logic [USED_W-1:0]  idx_q;
	logic [USED_W-1:0]  idx_d;
	logic [2*CNT_W-1:0] rd_q;
	logic [CNT_W-1:0]   rd_cnt;
	logic [CNT_W-1:0]   rd_size;
	logic [2*CNT_W-1:0] span_q;
	logic [2*CNT_W-1:0] prod_q;
	logic [OFS_W-1:0]   offset_q;
	logic [OFS_W-1:0]   ofs_sum;
	logic [OFS_W-1:0]   rank_ext;
	logic [OFS_W-1:0]   rank_diff;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   pos_sum;
	logic [POS_W-1:0]   ans_sum;
	logic               rhit;
	logic               shit;

	logic [STAT_W-1:0] st_q;
	logic [SLOT_W-1:0] ans_q;

	logic [RANK_W:0]     rsum;
	logic [SLOT_TOT_W:0] ssum;
	logic [SLOT_W-1:0]   slots_sat;

	// divider
	div_ctl_t         div_ctl;
	logic [CNT_W-1:0] quot;
	logic             div_last;

	// table memory: {count, size} per section
	logic [2*CNT_W-1:0] sec_mem [MAX_SECTIONS];

	// output register
	logic      rsp_valid_q;
	rsp_word_t rsp_q;
	logic      out_free;
	logic      acc;

	assign cmd.ready = (pc_q == L_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign uw = ucode(pc_q);

	assign rd_cnt    = rd_q[2*CNT_W-1:CNT_W];
	assign rd_size   = rd_q[CNT_W-1:0];
	assign rank_ext  = OFS_W'(rank_q);
	assign ofs_sum   = offset_q + OFS_W'(span_q);
	assign rank_diff = rank_ext - offset_q;
	// a zero span never holds the rank
	assign rhit      = (span_q != '0) && (ofs_sum > rank_ext);
	assign pos_sum   = pos_q + POS_W'(rd_cnt);
	assign shit      = POS_W'(slot_q) < pos_sum;
	assign ans_sum   = pos_q + POS_W'(quot);

	assign rsum      = {1'b0, rank_total_q} + (RANK_W + 1)'(prod_q);
	assign ssum      = {1'b0, slot_total_q} + (SLOT_TOT_W + 1)'(cnt_q);
	assign slots_sat = slot_total_q[SLOT_TOT_W-1] ? '1 : slot_total_q[SLOT_W-1:0];

	always_comb begin
		case (uw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_ALWAYS:   cond_true = 1'b1;
			C_ACC:      cond_true = acc;
			C_IS_RANK:  cond_true = (func_q == FN_RANK);
			C_IS_SIZE:  cond_true = (func_q == FN_SIZE);
			C_NOT_APP:  cond_true = (func_q != FN_APPEND);
			C_FULL:     cond_true = (used_q == USED_MAX);
			C_RANK_OOR: cond_true = (rank_q >= rank_total_q);
			C_SLOT_OOR: cond_true = (SLOT_TOT_W'(slot_q) >= slot_total_q);
			C_WALK_END: cond_true = (idx_q == used_q);
			C_RMISS:    cond_true = !rhit;
			C_SMISS:    cond_true = !shit;
			C_DIV_LAST: cond_true = div_last;
			C_OUT_FREE: cond_true = out_free;
			default:    cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (cond_true) begin
			pc_d = uw.tgt;
		end else if (uw.hold) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= L_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// next walk index; the memory is read at it so rd_q tracks idx_q
	always_comb begin
		idx_d = idx_q;
		case (uw.op)
			OP_CLEAR: idx_d = '0;
			OP_RSTEP: if (!rhit) idx_d = idx_q + 1'b1;
			OP_SSTEP: if (!shit) idx_d = idx_q + 1'b1;
			default:  idx_d = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_APP_MUL) begin
			sec_mem[used_q[IDX_W-1:0]] <= {cnt_q, size_q};
		end
		rd_q <= sec_mem[idx_d[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= cmd.data.func;
			cnt_q  <= cmd.data.sec_count;
			size_q <= cmd.data.sec_size;
			rank_q <= cmd.data.rank_index;
			slot_q <= cmd.data.slot_index;
		end
	end

	// totals and section count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			rank_total_q <= '0;
			slot_total_q <= '0;
		end else begin
			case (uw.op)
				OP_APP_MUL: used_q <= used_q + 1'b1;
				OP_APP_ADD: begin
					rank_total_q <= rsum[RANK_W] ? '1 : rsum[RANK_W-1:0];
					slot_total_q <= ssum[SLOT_TOT_W] ? '1 : ssum[SLOT_TOT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// walk and answer datapath
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		case (uw.op)
			OP_CLEAR: begin
				offset_q <= '0;
				pos_q    <= '0;
				st_q     <= ST_OK;
				ans_q    <= '0;
			end
			OP_APP_MUL:  prod_q <= cnt_q * size_q;
			OP_SET_FULL: st_q <= ST_FULL;
			OP_SET_OOR:  st_q <= ST_RANGE;
			OP_SPAN:     span_q <= rd_cnt * rd_size;
			OP_RSTEP: begin
				if (!rhit) begin
					offset_q <= ofs_sum;
					pos_q    <= pos_sum;
				end
			end
			OP_RANS: ans_q <= ans_sum[SLOT_W-1:0];
			OP_SSTEP: begin
				if (shit) begin
					ans_q <= SLOT_W'(rd_size);
				end else begin
					pos_q <= pos_sum;
				end
			end
			default: ;
		endcase
	end

	assign div_ctl.load = (uw.op == OP_RSTEP) && rhit;
	assign div_ctl.step = (uw.op == OP_DIV);

	srsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (rank_diff[2*CNT_W-1:0]),
		.divisor  (rd_size),
		.quotient (quot),
		.last     (div_last)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((uw.op == OP_POST) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((uw.op == OP_POST) && out_free) begin
			rsp_q.status      <= st_q;
			rsp_q.answer      <= ans_q;
			rsp_q.total_ranks <= rank_total_q;
			rsp_q.total_slots <= slots_sat;
		end
	end

endmodule

// ----- rtl/srsm_chk.sv -----
// Port-level checks on the section map, bound to the top level.
module srsm_chk
	import srsm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] rsp_status,
	input logic [SLOT_W-1:0] rsp_answer,
	input logic [RANK_W-1:0] rsp_total_ranks,
	input logic [SLOT_W-1:0] rsp_total_slots
);

	// stalled response stays valid with status, answer and rank total held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_answer) && $stable(rsp_total_ranks))
		else $error("response changed while stalled");

	// every error result answers zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_answer == '0)
		else $error("error response with nonzero answer");

	a_no_unused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != ST_UNUSED)
		else $error("unused status code");

	// ranks cannot exist without slots
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_total_slots == '0) |-> rsp_total_ranks == '0)
		else $error("ranks counted with no slots");

endmodule

bind section_rank_to_slot_map_core srsm_chk u_srsm_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.data.status),
	.rsp_answer      (rsp.data.answer),
	.rsp_total_ranks (rsp.data.total_ranks),
	.rsp_total_slots (rsp.data.total_slots)
);

// ----- tb/section_rank_to_slot_map_core_test.sv -----
// Self-checking testbench for the section rank-to-slot map core.
`timescale 1ns / 100ps

module section_rank_to_slot_map_core_test;
	import srsm_pkg::*;

	// func value 3 has no package name; the block treats it as a no-op
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam logic [63:0] RANK_CAP     = 64'hF_FFFF_FFFF;
	localparam logic [63:0] SLOT_SUM_CAP = 64'h1F_FFFF;
	localparam logic [63:0] SLOT_OUT_CAP = 64'hF_FFFF;

	localparam int N_RANDOM   = 830;
	localparam int QUIET_MAX  = 4000;  // cycles with no word moving on either side
	localparam int TAIL_WAIT  = 120;   // longer than the slowest lookup
	localparam int HOLD_AFTER = 300;   // responses seen before the long hold-off
	localparam int HOLD_LEN   = 600;
	localparam int MAX_PRINTS = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	srsm_chan_if #(.T(cmd_word_t)) cmd_ch ();
	srsm_chan_if #(.T(rsp_word_t)) rsp_ch ();

	section_rank_to_slot_map_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the section table and totals
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] tbl_count [MaxSectionsDef];
	logic [CNT_W-1:0] tbl_size  [MaxSectionsDef];
	int               tbl_used  = 0;
	logic [63:0]      tbl_ranks = '0;
	logic [63:0]      tbl_slots = '0;

	rsp_word_t want_rsp [$];       // responses still owed by the block
	cmd_word_t pending_cmds [$];   // command words not yet offered

	int  fail_count = 0;
	int  rsp_seen   = 0;
	int  quiet      = 0;
	bit  cmd_took   = 1'b0;        // set at the edge a command word moved

	// Stimulus shadow of the totals, so lookups can be aimed at and around
	// section boundaries. Kept in queue order, so it matches the table at
	// the moment each word is accepted.
	int          gen_used = 0;
	logic [63:0] rank_edges [$];
	logic [63:0] slot_edges [$];

	// Expected response for one command word; updates the table on append.
	function automatic rsp_word_t predict_map_rsp(cmd_word_t c);
		rsp_word_t   r;
		logic [63:0] span, base, slot_acc;
		bit          hit;
		r = '0;
		r.status = ST_OK;
		hit = 1'b0;
		base = '0;
		slot_acc = '0;
		case (c.func)
			FN_APPEND: begin
				if (tbl_used >= MaxSectionsDef) begin
					r.status = ST_FULL;
				end else begin
					tbl_count[tbl_used] = c.sec_count;
					tbl_size[tbl_used]  = c.sec_size;
					tbl_used++;
					tbl_ranks += 64'(c.sec_count) * 64'(c.sec_size);
					if (tbl_ranks > RANK_CAP)
						tbl_ranks = RANK_CAP;
					tbl_slots += 64'(c.sec_count);
					if (tbl_slots > SLOT_SUM_CAP)
						tbl_slots = SLOT_SUM_CAP;
				end
			end
			FN_RANK: begin
				if (64'(c.rank_index) >= tbl_ranks) begin
					r.status = ST_RANGE;
				end else begin
					// empty sections hold no ranks and are stepped over
					for (int i = 0; i < tbl_used; i++) begin
						span = 64'(tbl_count[i]) * 64'(tbl_size[i]);
						if (!hit) begin
							if (span == 0 || base + span <= 64'(c.rank_index)) begin
								base += span;
								slot_acc += 64'(tbl_count[i]);
							end else begin
								hit = 1'b1;
								slot_acc += (64'(c.rank_index) - base) / 64'(tbl_size[i]);
							end
						end
					end
					if (hit)
						r.answer = slot_acc[SLOT_W-1:0];
					else
						r.status = ST_RANGE;
				end
			end
			FN_SIZE: begin
				if (64'(c.slot_index) >= tbl_slots) begin
					r.status = ST_RANGE;
				end else begin
					// zero-size sections still number their slots
					for (int i = 0; i < tbl_used; i++) begin
						if (!hit && 64'(c.slot_index) < slot_acc + 64'(tbl_count[i])) begin
							hit = 1'b1;
							r.answer = SLOT_W'(tbl_size[i]);
						end
						slot_acc += 64'(tbl_count[i]);
					end
					if (!hit)
						r.status = ST_RANGE;
				end
			end
			default: ;
		endcase
		r.total_ranks = tbl_ranks[RANK_W-1:0];
		r.total_slots = (tbl_slots > SLOT_OUT_CAP) ? '1 : tbl_slots[SLOT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("%0t: MISMATCH %s: got %0h, want %0h (response %0d)",
				$realtime, what, got, want, rsp_seen);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// count or size of an appended section: extremes, small, or anything
	function automatic logic [CNT_W-1:0] pick_half();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return CNT_W'($urandom_range(1, 8));
			default: return CNT_W'($urandom);
		endcase
	endfunction

	// Mostly in range, with boundary hits and the odd wild index.
	function automatic logic [RANK_W-1:0] pick_rank();
		logic [63:0] total, e;
		total = rank_edges[rank_edges.size()-1];
		case ($urandom_range(0, 9))
			0: return RANK_W'(rand64());
			1: return RANK_W'(total);
			2: return RANK_W'(total - 1);
			3, 4: begin
				e = rank_edges[$urandom_range(0, rank_edges.size()-1)];
				return RANK_W'(e + 64'($urandom_range(0, 2)) - 1);
			end
			default: return (total == 0) ? RANK_W'(rand64()) : RANK_W'(rand64() % total);
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		logic [63:0] total, e;
		total = slot_edges[slot_edges.size()-1];
		case ($urandom_range(0, 9))
			0: return SLOT_W'($urandom);
			1: return SLOT_W'(total);
			2: return SLOT_W'(total - 1);
			3, 4: begin
				e = slot_edges[$urandom_range(0, slot_edges.size()-1)];
				return SLOT_W'(e + 64'($urandom_range(0, 2)) - 1);
			end
			default: return (total == 0) ? SLOT_W'($urandom) : SLOT_W'(64'($urandom) % total);
		endcase
	endfunction

	task automatic queue_op(logic [FUNC_W-1:0] f, logic [CNT_W-1:0] cnt,
		logic [CNT_W-1:0] sz, logic [RANK_W-1:0] rk, logic [SLOT_W-1:0] sl);
		cmd_word_t c;
		c.func = f;
		c.sec_count = cnt;
		c.sec_size = sz;
		c.rank_index = rk;
		c.slot_index = sl;
		pending_cmds.insert(pending_cmds.size(), c);
		if (f == FN_APPEND && gen_used < MaxSectionsDef) begin
			gen_used++;
			rank_edges.insert(rank_edges.size(),
				rank_edges[rank_edges.size()-1] + 64'(cnt) * 64'(sz));
			slot_edges.insert(slot_edges.size(),
				slot_edges[slot_edges.size()-1] + 64'(cnt));
		end
	endtask

	// ------------------------------------------------------------------
	// Command driver: bursts of words from the pending queue, random gaps
	// between bursts. Changes at the falling edge only.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_took) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.data  <= pending_cmds.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					// half the bursts run back to back; the rest leave gaps that
					// land anywhere in a lookup
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 90);
				end else begin
					burst_left--;
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response receiver: a mode picked at random and changed during the run
	// (always ready, alternating, mostly stalled, mostly ready), plus one long
	// hold-off so the output register fills and the command side backs up.
	// ------------------------------------------------------------------
	int rcv_tick  = 0;
	int rcv_mode  = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit rcv_rdy;

	always @(negedge clk) begin
		rcv_tick++;
		if (rcv_tick % 64 == 0)
			rcv_mode = $urandom_range(0, 3);
		if (!hold_done && rsp_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			rcv_rdy = 1'b0;
		end else begin
			case (rcv_mode)
				0:       rcv_rdy = 1'b1;
				1:       rcv_rdy = rcv_tick[0];
				2:       rcv_rdy = ($urandom_range(0, 9) < 3);
				default: rcv_rdy = ($urandom_range(0, 9) != 0);
			endcase
		end
		rsp_ch.ready <= rcv_rdy;
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on every accepted command word, checks every
	// accepted response word against the oldest prediction, and runs the
	// watchdog on cycles where nothing moves.
	// ------------------------------------------------------------------
	rsp_word_t got_rsp, want_now;

	always @(posedge clk) begin
		cmd_took = 1'b0;
		if (arst_n) begin
			quiet++;
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmd_took = 1'b1;
				quiet = 0;
				want_rsp.insert(want_rsp.size(), predict_map_rsp(cmd_ch.data));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				quiet = 0;
				got_rsp = rsp_ch.data;
				if (want_rsp.size() == 0) begin
					report_mismatch("unexpected response, status", 64'(got_rsp.status), '0);
				end else begin
					want_now = want_rsp.pop_front();
					if (got_rsp.status !== want_now.status)
						report_mismatch("status", 64'(got_rsp.status), 64'(want_now.status));
					if (got_rsp.answer !== want_now.answer)
						report_mismatch("answer", 64'(got_rsp.answer), 64'(want_now.answer));
					if (got_rsp.total_ranks !== want_now.total_ranks)
						report_mismatch("total_ranks", 64'(got_rsp.total_ranks),
							64'(want_now.total_ranks));
					if (got_rsp.total_slots !== want_now.total_slots)
						report_mismatch("total_slots", 64'(got_rsp.total_slots),
							64'(want_now.total_slots));
				end
				rsp_seen++;
			end
			if (quiet >= QUIET_MAX) begin
				$display("%0t: watchdog: no word moved in %0d cycles", $realtime, quiet);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	int pick;

	initial begin
		rank_edges.insert(0, '0);
		slot_edges.insert(0, '0);

		// Directed part. Empty table first: every lookup is out of range.
		queue_op(FN_RANK, '0, '0, '0, '0);
		queue_op(FN_SIZE, '1, '1, '1, '0);
		queue_op(FN_UNUSED, '1, '1, '1, '1);
		// zero-count section, then zero-size section that still numbers slots
		queue_op(FN_APPEND, '0, '1, '0, '0);
		queue_op(FN_APPEND, 16'd5, '0, '1, '1);
		queue_op(FN_SIZE, '0, '0, '0, '0);
		queue_op(FN_SIZE, '0, '0, '0, 20'd4);
		queue_op(FN_SIZE, '0, '0, '0, 20'd5);
		queue_op(FN_RANK, '0, '0, '0, '0);   // no ranks yet
		// largest section, then a small one after it
		queue_op(FN_APPEND, '1, '1, '0, '0);
		queue_op(FN_APPEND, 16'd3, 16'd7, '0, '0);
		queue_op(FN_RANK, '0, '0, '0, '0);   // lands past both empty sections
		queue_op(FN_RANK, '0, '0, RANK_W'(rank_edges[rank_edges.size()-1] - 1), '0);
		queue_op(FN_RANK, '0, '0, RANK_W'(rank_edges[rank_edges.size()-1]), '0);
		queue_op(FN_RANK, '0, '0, '1, '0);
		queue_op(FN_SIZE, '0, '0, '0, SLOT_W'(slot_edges[slot_edges.size()-1] - 1));
		queue_op(FN_SIZE, '0, '0, '0, SLOT_W'(slot_edges[slot_edges.size()-1]));
		queue_op(FN_SIZE, '0, '0, '0, '1);
		queue_op(FN_UNUSED, '0, '0, '0, '0);
		queue_op(FN_APPEND, 16'd1, 16'd1, '0, '0);
		queue_op(FN_RANK, '0, '0, RANK_W'(rank_edges[rank_edges.size()-1] - 1), '0);

		// Random part: the table fills within the first hundred or so words,
		// after which appends are rarer and all hit table full.
		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 99);
			if ((gen_used < MaxSectionsDef && pick < 9) || pick < 4)
				queue_op(FN_APPEND, pick_half(), pick_half(), RANK_W'(rand64()), SLOT_W'($urandom));
			else if (pick < 7)
				queue_op(FN_UNUSED, CNT_W'($urandom), CNT_W'($urandom), RANK_W'(rand64()),
					SLOT_W'($urandom));
			else if (pick < 55)
				queue_op(FN_RANK, CNT_W'($urandom), CNT_W'($urandom), pick_rank(),
					SLOT_W'($urandom));
			else
				queue_op(FN_SIZE, CNT_W'($urandom), CNT_W'($urandom), RANK_W'(rand64()),
					pick_slot());
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || cmd_ch.valid || want_rsp.size() != 0)
			@(posedge clk);
		// anything arriving now has no prediction and is flagged by the monitor
		repeat (TAIL_WAIT) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
